### rtl/core/vpts_pkg.sv
// Shared types, constants and saturation helper for the vertex projection pipeline.
// No dependencies; used by vertex_project_to_screen and its checker.
package vpts_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int NUM_COEFS     = 18;
	localparam int NUM_REGS      = 7;
	localparam int REG_IDX_W     = 3;
	localparam int COEF_IDX_W    = 5;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LEFT   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TOP    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_NEAR   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FAR    = 3'd6;

	localparam logic signed [DATA_W-1:0] RST_WIDTH  = 32'sd41943040;
	localparam logic signed [DATA_W-1:0] RST_HEIGHT = 32'sd31457280;
	localparam logic signed [DATA_W-1:0] RST_FAR    = 32'sd65536;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PROJECT = 1'b1;

	localparam logic MODE_PERSP = 1'b0;
	localparam logic MODE_ORTHO = 1'b1;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     ovf;
	} sat_t;

	function automatic sat_t sat32(input logic signed [65:0] v);
		sat_t r;
		r.ovf = 1'b1;
		if (v > 66'sd2147483647) begin
			r.val = S32_MAX;
		end else if (v < -66'sd2147483648) begin
			r.val = S32_MIN;
		end else begin
			r.val = v[DATA_W-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

### rtl/core/vertex_project_to_screen.sv
// Fixed-point vertex projection: matrix, projection, divide and viewport pipeline.
// Depends on vpts_pkg.
//
// Usage: the request channel (in_valid/in_ready) carries load and project
// requests. A load writes one of 18 coefficients as it is accepted and yields
// no result; a project request yields one result on the out_valid/out_ready
// channel. Configuration is written through cfg_we/cfg_index/cfg_data while
// no request is in flight.
// Throughput is one request per cycle while the receiver takes results; the
// depth is set by the restoring divider, one quotient bit per stage over
// 32 + FRAC_BITS stages, three lanes side by side.
// Each stage advances when it is empty or the next stage advances, so bubbles
// close up while the receiver stalls; in_ready drops only when every stage
// holds a request and out_ready is low.
// Reset clears the coefficient store, the configuration registers to their
// defaults and all stage valid bits.
module vertex_project_to_screen #(
	parameter int FRAC_BITS = vpts_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [vpts_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [vpts_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  op,
	input  logic [vpts_pkg::COEF_IDX_W-1:0]       coef_index,
	input  logic signed [vpts_pkg::DATA_W-1:0]    coef_value,
	input  logic signed [vpts_pkg::DATA_W-1:0]    point_x,
	input  logic signed [vpts_pkg::DATA_W-1:0]    point_y,
	input  logic signed [vpts_pkg::DATA_W-1:0]    point_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [vpts_pkg::DATA_W-1:0]    screen_x,
	output logic signed [vpts_pkg::DATA_W-1:0]    screen_y,
	output logic signed [vpts_pkg::DATA_W-1:0]    screen_z,
	output logic                                  overflow
);

	localparam int DW  = vpts_pkg::DATA_W;
	localparam int NW  = DW + FRAC_BITS;
	localparam int ST5 = 4;
	localparam int ST6 = 5 + NW;
	localparam int ST7 = 6 + NW;
	localparam int NS  = 8 + NW;

	// ---------------- configuration ----------------
	logic                 mode_q;
	logic signed [DW-1:0] left_q, top_q, width_q, height_q, near_q, far_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= vpts_pkg::MODE_PERSP;
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= vpts_pkg::RST_WIDTH;
			height_q <= vpts_pkg::RST_HEIGHT;
			near_q   <= '0;
			far_q    <= vpts_pkg::RST_FAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vpts_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				vpts_pkg::REG_LEFT:   left_q   <= cfg_data;
				vpts_pkg::REG_TOP:    top_q    <= cfg_data;
				vpts_pkg::REG_WIDTH:  width_q  <= cfg_data;
				vpts_pkg::REG_HEIGHT: height_q <= cfg_data;
				vpts_pkg::REG_NEAR:   near_q   <= cfg_data;
				vpts_pkg::REG_FAR:    far_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [DW-1:0] hw, hh;
	vpts_pkg::sat_t       dr;
	assign hw = width_q >>> 1;
	assign hh = height_q >>> 1;
	assign dr = vpts_pkg::sat32(66'(far_q) - 66'(near_q));

	// ---------------- stage control ----------------
	logic [NS-1:0] v;
	logic [NS:0]   en;
	logic          acc, proj_acc;

	assign en[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_en
		assign en[k] = ~v[k] | en[k+1];
	end

	assign in_ready = en[0];
	assign acc      = in_valid & in_ready;
	assign proj_acc = acc & (op == vpts_pkg::OP_PROJECT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					v[k] <= (k == 0) ? proj_acc : v[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	// ---------------- coefficient store ----------------
	logic signed [DW-1:0] coef_q [vpts_pkg::NUM_COEFS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vpts_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (acc && op == vpts_pkg::OP_LOAD &&
		             coef_index < vpts_pkg::COEF_IDX_W'(vpts_pkg::NUM_COEFS)) begin
			coef_q[coef_index] <= coef_value;
		end
	end

	// ---------------- s1: matrix products ----------------
	logic signed [63:0]   prod_s1 [9];
	logic signed [DW-1:0] bias_s1 [3];
	logic signed [DW-1:0] pc_s1 [6];
	logic signed [DW-1:0] pt [3];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r*3+c] <= (64'(coef_q[r*4+c]) * 64'(pt[c])) >>> FRAC_BITS;
				end
				bias_s1[r] <= coef_q[r*4+3];
			end
			// capture projection terms so later loads cannot reach this request
			for (int i = 0; i < 6; i++) begin
				pc_s1[i] <= coef_q[12+i];
			end
		end
	end

	// ---------------- s2: view space ----------------
	logic signed [DW-1:0] view_s2 [3];
	logic signed [DW-1:0] pc_s2 [6];
	logic                 ovf_s2;
	vpts_pkg::sat_t       vs [3];

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			vs[r] = vpts_pkg::sat32(66'(prod_s1[r*3]) + 66'(prod_s1[r*3+1]) +
			                        66'(prod_s1[r*3+2]) + 66'(bias_s1[r]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int r = 0; r < 3; r++) begin
				view_s2[r] <= vs[r].val;
			end
			pc_s2  <= pc_s1;
			ovf_s2 <= vs[0].ovf | vs[1].ovf | vs[2].ovf;
		end
	end

	// ---------------- s3: projection products ----------------
	logic signed [63:0]   mp_s3 [5];
	logic signed [DW-1:0] pc_s3 [6];
	logic signed [DW-1:0] vz_s3;
	logic                 ovf_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mp_s3[0] <= (64'(pc_s2[0]) * 64'(view_s2[0])) >>> FRAC_BITS;
			mp_s3[1] <= (64'(pc_s2[1]) * 64'(view_s2[2])) >>> FRAC_BITS;
			mp_s3[2] <= (64'(pc_s2[2]) * 64'(view_s2[1])) >>> FRAC_BITS;
			mp_s3[3] <= (64'(pc_s2[3]) * 64'(view_s2[2])) >>> FRAC_BITS;
			mp_s3[4] <= (64'(pc_s2[4]) * 64'(view_s2[2])) >>> FRAC_BITS;
			pc_s3    <= pc_s2;
			vz_s3    <= view_s2[2];
			ovf_s3   <= ovf_s2;
		end
	end

	// ---------------- s4: projection sums and divisor ----------------
	logic signed [DW-1:0] pn_s4 [3];
	logic signed [DW:0]   w_s4;
	logic                 ovf_s4;
	vpts_pkg::sat_t       ps [3];
	logic signed [DW:0]   wn;

	always_comb begin
		if (mode_q == vpts_pkg::MODE_ORTHO) begin
			ps[0] = vpts_pkg::sat32(66'(mp_s3[0]) + 66'(pc_s3[1]));
			ps[1] = vpts_pkg::sat32(66'(mp_s3[2]) + 66'(pc_s3[3]));
			// divide by one: numerator scale cancels the shift
			wn    = (DW+1)'(1) <<< FRAC_BITS;
		end else begin
			ps[0] = vpts_pkg::sat32(66'(mp_s3[0]) + 66'(mp_s3[1]));
			ps[1] = vpts_pkg::sat32(66'(mp_s3[2]) + 66'(mp_s3[3]));
			wn    = -(DW+1)'(vz_s3);
			if (vz_s3 == '0) begin
				wn = (DW+1)'(1);
			end
		end
		ps[2] = vpts_pkg::sat32(66'(mp_s3[4]) + 66'(pc_s3[5]));
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < 3; l++) begin
				pn_s4[l] <= ps[l].val;
			end
			w_s4   <= wn;
			ovf_s4 <= ovf_s3 | ps[0].ovf | ps[1].ovf | ps[2].ovf;
		end
	end

	// ---------------- s5 and divider steps ----------------
	// index 0 holds magnitudes, index j the state after quotient bit j
	logic [DW-1:0] rem_s5 [NW+1][3];
	logic [NW-1:0] nq_s5  [NW+1][3];
	logic          neg_s5 [NW+1][3];
	logic [DW-1:0] d_s5   [NW+1];
	logic          ovf_s5 [NW+1];
	logic [DW:0]   wmag;

	assign wmag = w_s4[DW] ? (DW+1)'(-w_s4) : (DW+1)'(w_s4);

	always_ff @(posedge clk) begin
		if (en[ST5]) begin
			for (int l = 0; l < 3; l++) begin
				rem_s5[0][l] <= '0;
				nq_s5[0][l]  <= {(pn_s4[l][DW-1] ? DW'(-pn_s4[l]) : DW'(pn_s4[l])),
				                 FRAC_BITS'(0)};
				neg_s5[0][l] <= pn_s4[l][DW-1] ^ w_s4[DW];
			end
			d_s5[0]   <= wmag[DW-1:0];
			ovf_s5[0] <= ovf_s4;
		end
	end

	for (genvar j = 1; j <= NW; j++) begin : g_div
		logic [DW:0]   t    [3];
		logic [DW+1:0] diff [3];
		logic          ge   [3];
		for (genvar l = 0; l < 3; l++) begin : g_lane
			assign t[l]    = {rem_s5[j-1][l], nq_s5[j-1][l][NW-1]};
			assign diff[l] = {1'b0, t[l]} - {2'b00, d_s5[j-1]};
			assign ge[l]   = ~diff[l][DW+1];
		end
		always_ff @(posedge clk) begin
			if (en[ST5+j]) begin
				for (int l = 0; l < 3; l++) begin
					rem_s5[j][l] <= ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
					nq_s5[j][l]  <= {nq_s5[j-1][l][NW-2:0], ge[l]};
					neg_s5[j][l] <= neg_s5[j-1][l];
				end
				d_s5[j]   <= d_s5[j-1];
				ovf_s5[j] <= ovf_s5[j-1];
			end
		end
	end

	// ---------------- s6: signed quotient ----------------
	logic signed [DW-1:0] nrm_s6 [3];
	logic                 ovf_s6;
	vpts_pkg::sat_t       qs [3];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (neg_s5[NW][l]) begin
				qs[l].ovf = (|nq_s5[NW][l][NW-1:DW]) |
				            (nq_s5[NW][l][DW-1] & (|nq_s5[NW][l][DW-2:0]));
				qs[l].val = qs[l].ovf ? vpts_pkg::S32_MIN : -nq_s5[NW][l][DW-1:0];
			end else begin
				qs[l].ovf = |nq_s5[NW][l][NW-1:DW-1];
				qs[l].val = qs[l].ovf ? vpts_pkg::S32_MAX : nq_s5[NW][l][DW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST6]) begin
			for (int l = 0; l < 3; l++) begin
				nrm_s6[l] <= qs[l].val;
			end
			ovf_s6 <= ovf_s5[NW] | qs[0].ovf | qs[1].ovf | qs[2].ovf;
		end
	end

	// ---------------- s7: viewport products ----------------
	logic signed [63:0] vpm_s7 [3];
	logic               ovf_s7;

	always_ff @(posedge clk) begin
		if (en[ST7]) begin
			vpm_s7[0] <= (64'(hw) * 64'(nrm_s6[0])) >>> FRAC_BITS;
			vpm_s7[1] <= (64'(hh) * 64'(nrm_s6[1])) >>> FRAC_BITS;
			vpm_s7[2] <= (64'(dr.val) * 64'(nrm_s6[2])) >>> FRAC_BITS;
			ovf_s7    <= ovf_s6 | dr.ovf;
		end
	end

	// ---------------- s8: viewport sums, output register ----------------
	logic signed [DW-1:0] scr_s8 [3];
	logic                 ovf_s8;
	vpts_pkg::sat_t       rs [3];

	always_comb begin
		rs[0] = vpts_pkg::sat32(66'(vpm_s7[0]) + 66'(left_q) + 66'(hw));
		rs[1] = vpts_pkg::sat32(66'(top_q) + 66'(hh) - 66'(vpm_s7[1]));
		rs[2] = vpts_pkg::sat32(66'(vpm_s7[2]) + 66'(far_q));
	end

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			for (int l = 0; l < 3; l++) begin
				scr_s8[l] <= rs[l].val;
			end
			ovf_s8 <= ovf_s7 | rs[0].ovf | rs[1].ovf | rs[2].ovf;
		end
	end

	assign out_valid = v[NS-1];
	assign screen_x  = scr_s8[0];
	assign screen_y  = scr_s8[1];
	assign screen_z  = scr_s8[2];
	assign overflow  = ovf_s8;

endmodule

### rtl/core/vpts_check.sv
// Port-level checker for vertex_project_to_screen, attached by bind.
// Depends on vpts_pkg and the top level's ports.
module vpts_check (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [vpts_pkg::DATA_W-1:0]  screen_x,
	input logic signed [vpts_pkg::DATA_W-1:0]  screen_y,
	input logic signed [vpts_pkg::DATA_W-1:0]  screen_z,
	input logic                                overflow
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(screen_x) &&
		$stable(screen_y) && $stable(screen_z) && $stable(overflow))
		else $error("stalled result changed");

	// reset clears every stage
	a_reset_empty: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result shown during reset");

	// requests back up only behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused without output stall");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with empty output");

endmodule

bind vertex_project_to_screen vpts_check u_vpts_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.screen_x  (screen_x),
	.screen_y  (screen_y),
	.screen_z  (screen_z),
	.overflow  (overflow)
);

### sim/tb_top.sv
// Self-checking bench for vertex_project_to_screen: directed and random load/project
// requests, predicted results compared in order. Depends on vpts_pkg and block RTL.
`timescale 1ns / 100ps

module tb_top;

	localparam int FB = vpts_pkg::FRAC_BITS_DEF;
	localparam int PIPE_LAT = 40 + FB;
	localparam longint LIMIT = 2000000;
	localparam int DW = vpts_pkg::DATA_W;
	localparam int CIW = vpts_pkg::COEF_IDX_W;
	localparam int RIW = vpts_pkg::REG_IDX_W;

	typedef struct packed {
		logic                 op;
		logic [CIW-1:0]       idx;
		logic signed [DW-1:0] cv;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] sx;
		logic signed [DW-1:0] sy;
		logic signed [DW-1:0] sz;
		logic                 ovf;
	} scr_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RIW-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = 1'b0;
	logic [CIW-1:0] coef_index = '0;
	logic signed [DW-1:0] coef_value = '0, point_x = '0, point_y = '0, point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] screen_x, screen_y, screen_z;
	logic overflow;

	vertex_project_to_screen dut (.*);

	req_t pending_reqs[$];
	scr_t expected_screen[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 1'b0;
	int in_hold = 0, out_hold = 0;
	// in_ready as seen at the last rising edge
	bit in_ready_seen = 1'b0;

	// predictor state
	logic signed [DW-1:0] coefs[vpts_pkg::NUM_COEFS];
	logic signed [DW-1:0] vp[vpts_pkg::NUM_REGS];
	bit pov;

	function automatic longint clip(longint v);
		if (v > 64'sd2147483647) begin
			pov = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			pov = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b) >>> FB;
	endfunction

	function automatic longint qdiv(longint n, longint d);
		return clip((n * (64'sd1 <<< FB)) / d);
	endfunction

	function automatic longint mrow(int r, longint x, longint y, longint z);
		return clip(qmul(coefs[4*r], x) + qmul(coefs[4*r+1], y) +
			qmul(coefs[4*r+2], z) + coefs[4*r+3]);
	endfunction

	function automatic scr_t project_point(req_t q);
		longint x, y, z, vx, vy, vz, px, py, pz, w, nx, ny, nz, hw, hh, dr;
		scr_t s;
		pov = 1'b0;
		x = q.x;
		y = q.y;
		z = q.z;
		vx = mrow(0, x, y, z);
		vy = mrow(1, x, y, z);
		vz = mrow(2, x, y, z);
		if (vp[vpts_pkg::REG_MODE][0] == vpts_pkg::MODE_PERSP) begin
			px = clip(qmul(coefs[12], vx) + qmul(coefs[13], vz));
			py = clip(qmul(coefs[14], vy) + qmul(coefs[15], vz));
			pz = clip(qmul(coefs[16], vz) + coefs[17]);
			w = -vz;
			if (w == 0) w = 1;
			nx = qdiv(px, w);
			ny = qdiv(py, w);
			nz = qdiv(pz, w);
		end else begin
			nx = clip(qmul(coefs[12], vx) + coefs[13]);
			ny = clip(qmul(coefs[14], vy) + coefs[15]);
			nz = clip(qmul(coefs[16], vz) + coefs[17]);
		end
		hw = longint'(vp[vpts_pkg::REG_WIDTH]) >>> 1;
		hh = longint'(vp[vpts_pkg::REG_HEIGHT]) >>> 1;
		dr = clip(longint'(vp[vpts_pkg::REG_FAR]) - longint'(vp[vpts_pkg::REG_NEAR]));
		s.sx = DW'(clip(qmul(hw, nx) + vp[vpts_pkg::REG_LEFT] + hw));
		s.sy = DW'(clip(-qmul(hh, ny) + vp[vpts_pkg::REG_TOP] + hh));
		s.sz = DW'(clip(qmul(dr, nz) + vp[vpts_pkg::REG_FAR]));
		s.ovf = pov;
		return s;
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// driver: predict on acceptance, present next request at falling edge
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_t q;
			q = pending_reqs.pop_front();
			if (q.op == vpts_pkg::OP_LOAD) begin
				if (q.idx < vpts_pkg::NUM_COEFS) coefs[q.idx] = q.cv;
			end else begin
				expected_screen.push_back(project_point(q));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_valid && !in_ready_seen)) begin
				if (in_hold > 0) begin
					in_hold <= in_hold - 1;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 19) == 0) begin
					in_hold <= $urandom_range(1, 18);
					in_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					in_valid <= 1'b1;
					op <= pending_reqs[0].op;
					coef_index <= pending_reqs[0].idx;
					coef_value <= pending_reqs[0].cv;
					point_x <= pending_reqs[0].x;
					point_y <= pending_reqs[0].y;
					point_z <= pending_reqs[0].z;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if (out_hold > 0) begin
				out_hold <= out_hold - 1;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 19) == 0) begin
				out_hold <= $urandom_range(1, 18);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) in_ready_seen <= in_ready;

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			scr_t e;
			if (expected_screen.size() == 0) begin
				$error("result with no project request pending");
				errors++;
			end else begin
				e = expected_screen.pop_front();
				if (screen_x !== e.sx) begin
					$error("screen_x expected %0d got %0d", e.sx, screen_x);
					errors++;
				end
				if (screen_y !== e.sy) begin
					$error("screen_y expected %0d got %0d", e.sy, screen_y);
					errors++;
				end
				if (screen_z !== e.sz) begin
					$error("screen_z expected %0d got %0d", e.sz, screen_z);
					errors++;
				end
				if (overflow !== e.ovf) begin
					$error("overflow expected %0d got %0d", e.ovf, overflow);
					errors++;
				end
			end
		end
	end

	function automatic logic [31:0] rnd_q();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 | $urandom_range(0, 3);
			1: return 32'h7fff_ffff - $urandom_range(0, 3);
			2: return $urandom();
			default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		endcase
	endfunction

	function automatic req_t mk_load(int i, logic [31:0] v);
		req_t q;
		q.op = vpts_pkg::OP_LOAD;
		q.idx = i[CIW-1:0];
		q.cv = v;
		q.x = $urandom();
		q.y = $urandom();
		q.z = $urandom();
		return q;
	endfunction

	function automatic req_t mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		req_t q;
		q.op = vpts_pkg::OP_PROJECT;
		q.idx = CIW'($urandom());
		q.cv = $urandom();
		q.x = x;
		q.y = y;
		q.z = z;
		return q;
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || in_valid || expected_screen.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [RIW-1:0] i, logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_data <= v;
		@(posedge clk);
		if (i == vpts_pkg::REG_MODE) vp[i] = {31'd0, v[0]};
		else vp[i] = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 9) == 0)
				pending_reqs.push_back(mk_load($urandom_range(0, 31), rnd_q()));
			else
				pending_reqs.push_back(mk_point(rnd_q(), rnd_q(), rnd_q()));
		end
	endtask

	initial begin
		for (int i = 0; i < vpts_pkg::NUM_COEFS; i++) coefs[i] = '0;
		vp[vpts_pkg::REG_MODE] = '0;
		vp[vpts_pkg::REG_LEFT] = '0;
		vp[vpts_pkg::REG_TOP] = '0;
		vp[vpts_pkg::REG_WIDTH] = vpts_pkg::RST_WIDTH;
		vp[vpts_pkg::REG_HEIGHT] = vpts_pkg::RST_HEIGHT;
		vp[vpts_pkg::REG_NEAR] = '0;
		vp[vpts_pkg::REG_FAR] = vpts_pkg::RST_FAR;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: zero store, identity-like setup, zero divisor, extremes
		pending_reqs.push_back(mk_point(32'h0, 32'h0, 32'h0));
		for (int i = 0; i < 12; i++)
			pending_reqs.push_back(mk_load(i, (i % 5 == 0) ? 32'h0001_0000 : 32'h0));
		pending_reqs.push_back(mk_load(12, 32'h0001_0000));
		pending_reqs.push_back(mk_load(14, 32'h0001_0000));
		pending_reqs.push_back(mk_load(16, 32'hffff_0000));
		pending_reqs.push_back(mk_load(31, 32'hdead_beef));
		pending_reqs.push_back(mk_point(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000));
		pending_reqs.push_back(mk_point(32'h0001_0000, 32'h0001_0000, 32'h0));
		pending_reqs.push_back(mk_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		pending_reqs.push_back(mk_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(vpts_pkg::REG_MODE, {31'd0, ph[0]});
			write_reg(vpts_pkg::REG_LEFT,
				(ph == 2) ? 32'h8000_0000 : (ph == 3) ? 32'h7fff_ffff : rnd_q());
			write_reg(vpts_pkg::REG_TOP, (ph == 2) ? 32'h7fff_ffff : rnd_q());
			write_reg(vpts_pkg::REG_WIDTH, (ph == 3) ? 32'h8000_0000
				: (ph == 2) ? 32'h7fff_ffff : 32'h0280_0000);
			write_reg(vpts_pkg::REG_HEIGHT, (ph == 3) ? 32'h7fff_ffff : 32'h01e0_0000);
			write_reg(vpts_pkg::REG_NEAR, (ph == 4) ? 32'h8000_0000 : rnd_q());
			write_reg(vpts_pkg::REG_FAR, (ph == 4) ? 32'h7fff_ffff : rnd_q());
			if (ph == 7) calm = 1'b1;
			for (int i = 0; i < vpts_pkg::NUM_COEFS; i++)
				pending_reqs.push_back(mk_load(i, rnd_q()));
			random_phase(230);
			drain();
		end

		if (errors == 0 && expected_screen.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
